>>> hw/rtl/cbrm_pkg.sv
package cbrm_pkg;

    // Fixed-point layout
    localparam int COEF_FRAC_BITS = 14;
    localparam int COEF_W         = 16;
    localparam int STATE_WIDTH    = 48;
    localparam int STATE_FRAC     = 16;
    localparam int SAMPLE_W       = 32;
    localparam int VOL_W          = 32;
    localparam int VOL_SPLIT      = 16;
    localparam int PROD_FRAC      = STATE_FRAC + 24;
    localparam int MUL_B_W        = COEF_W + 1;
    localparam int PROD_W         = STATE_WIDTH + MUL_B_W;
    localparam int ACC_W          = PROD_W + VOL_SPLIT;
    localparam int SH_W           = ACC_W - COEF_FRAC_BITS;
    localparam int FL_W           = ACC_W - PROD_FRAC;
    localparam int TAPS           = 5;
    localparam int TAP_W          = $clog2(TAPS);

    // Register indexes on the config port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_FF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_S1_FB   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_FF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_S2_FB   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd6;
    localparam int CFG_DATA_W = 48;

    // state_mode bits
    localparam int MODE_CLR1 = 0;
    localparam int MODE_CLR2 = 1;
    localparam int MODE_SAVE = 2;

    typedef logic signed [STATE_WIDTH-1:0] state_t;
    typedef logic signed [SAMPLE_W-1:0]    sample_t;
    typedef logic signed [MUL_B_W-1:0]     mul_b_t;
    typedef logic signed [ACC_W-1:0]       acc_t;

    typedef struct packed {
        logic valid;
        logic clear;
        logic shift;
    } mac_op_t;

    typedef struct packed {
        logic [47:0]          ff1;
        logic [31:0]          fb1;
        logic [47:0]          ff2;
        logic [31:0]          fb2;
        logic signed [31:0]   start_vol;
        logic signed [31:0]   vol_step;
        logic [2:0]           mode;
    } cfg_t;

    // acc >>> COEF_FRAC_BITS, saturated to the stage width
    function automatic state_t sat_state(input acc_t acc);
        logic [SH_W-1:0] sh;
        logic [SH_W-STATE_WIDTH:0] top;
        state_t r;
        sh  = acc[ACC_W-1:COEF_FRAC_BITS];
        top = sh[SH_W-1:STATE_WIDTH-1];
        if ((&top) || !(|top))
            r = sh[STATE_WIDTH-1:0];
        else if (sh[SH_W-1])
            r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
        return r;
    endfunction

    // Signed 16-bit slot k of a packed coefficient word, widened for the multiplier
    function automatic mul_b_t coef_slot(input logic [47:0] word, input logic [1:0] k);
        logic [COEF_W-1:0] c;
        case (k)
            2'd0:    c = word[15:0];
            2'd1:    c = word[31:16];
            2'd2:    c = word[47:32];
            default: c = '0;
        endcase
        return {c[COEF_W-1], c};
    endfunction

endpackage

>>> hw/rtl/cbrm_mac.sv
module cbrm_mac (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cbrm_pkg::mac_op_t       op,
    input  cbrm_pkg::state_t        a,
    input  cbrm_pkg::mul_b_t        b,
    output cbrm_pkg::acc_t          acc
);

    cbrm_pkg::mac_op_t                      op_reg;
    logic signed [cbrm_pkg::PROD_W-1:0]     prod_reg;
    cbrm_pkg::acc_t                         acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg <= '0;
        end else begin
            op_reg <= op;
        end
    end

    // multiply, register, then accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        if (op_reg.valid) begin
            if (op_reg.clear)
                acc_reg <= cbrm_pkg::ACC_W'(prod_reg);
            else if (op_reg.shift)
                acc_reg <= (acc_reg <<< cbrm_pkg::VOL_SPLIT) + cbrm_pkg::ACC_W'(prod_reg);
            else
                acc_reg <= acc_reg + cbrm_pkg::ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

>>> hw/rtl/cbrm_seq.sv
module cbrm_seq (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  cbrm_pkg::sample_t       in_pcm,
    input  cbrm_pkg::sample_t       in_mix,
    input  logic                    in_frame,
    input  cbrm_pkg::cfg_t          cfg,
    input  logic                    out_hold,
    output logic                    out_load,
    output cbrm_pkg::sample_t       out_mix,
    output cbrm_pkg::sample_t       out_contrib,
    output cbrm_pkg::mac_op_t       mac_op,
    output cbrm_pkg::state_t        mac_a,
    output cbrm_pkg::mul_b_t        mac_b,
    input  cbrm_pkg::acc_t          mac_acc
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SYNC, ST_S1_MAC, ST_S1_DRAIN, ST_S1_DONE,
        ST_S2_MAC, ST_S2_DRAIN, ST_S2_DONE,
        ST_VOL_HI, ST_VOL_LO, ST_VOL_DRAIN, ST_CLAMP, ST_MIX
    } seq_state_t;

    seq_state_t                     state_reg;
    logic [cbrm_pkg::TAP_W-1:0]     tap_reg;
    cbrm_pkg::sample_t              x_reg, m_reg;
    cbrm_pkg::sample_t              x1_reg, x2_reg;
    cbrm_pkg::state_t               y1a_reg, y2a_reg;
    cbrm_pkg::state_t               x1b_reg, x2b_reg, y1b_reg, y2b_reg;
    cbrm_pkg::state_t               cur_y_reg;
    cbrm_pkg::state_t               saved1_reg [4];
    cbrm_pkg::state_t               saved2_reg [4];
    logic signed [31:0]             vol_reg;
    cbrm_pkg::sample_t              pcf_reg, contrib_reg;
    logic                           frac_nz_reg;

    cbrm_pkg::state_t               y_sat;
    cbrm_pkg::sample_t              pcf_next, contrib_next, mix_val;
    logic                           frac_nz_next;
    logic signed [31:0]             vol_next;
    logic [cbrm_pkg::FL_W-1:0]      fl;
    logic [cbrm_pkg::FL_W-cbrm_pkg::SAMPLE_W:0] fl_top;
    logic [32:0]                    vsum, msum;

    assign in_ready = (state_reg == ST_IDLE);
    assign y_sat    = cbrm_pkg::sat_state(mac_acc);

    // operand select for the shared multiplier
    always_comb begin
        mac_op = '0;
        mac_a  = '0;
        mac_b  = '0;
        case (state_reg)
            ST_S1_MAC: begin
                mac_op.valid = 1'b1;
                mac_op.clear = (tap_reg == '0);
                case (tap_reg)
                    3'd0:    mac_a = {x_reg,  {cbrm_pkg::STATE_FRAC{1'b0}}};
                    3'd1:    mac_a = {x1_reg, {cbrm_pkg::STATE_FRAC{1'b0}}};
                    3'd2:    mac_a = {x2_reg, {cbrm_pkg::STATE_FRAC{1'b0}}};
                    3'd3:    mac_a = y1a_reg;
                    default: mac_a = y2a_reg;
                endcase
                if (tap_reg < 3'd3)
                    mac_b = cbrm_pkg::coef_slot(cfg.ff1, tap_reg[1:0]);
                else
                    mac_b = cbrm_pkg::coef_slot({16'b0, cfg.fb1}, 2'(tap_reg - 3'd3));
            end
            ST_S2_MAC: begin
                mac_op.valid = 1'b1;
                mac_op.clear = (tap_reg == '0);
                case (tap_reg)
                    3'd0:    mac_a = cur_y_reg;
                    3'd1:    mac_a = x1b_reg;
                    3'd2:    mac_a = x2b_reg;
                    3'd3:    mac_a = y1b_reg;
                    default: mac_a = y2b_reg;
                endcase
                if (tap_reg < 3'd3)
                    mac_b = cbrm_pkg::coef_slot(cfg.ff2, tap_reg[1:0]);
                else
                    mac_b = cbrm_pkg::coef_slot({16'b0, cfg.fb2}, 2'(tap_reg - 3'd3));
            end
            ST_VOL_HI: begin
                mac_op.valid = 1'b1;
                mac_op.clear = 1'b1;
                mac_a        = cur_y_reg;
                mac_b        = {vol_reg[31], vol_reg[31:16]};
            end
            ST_VOL_LO: begin
                mac_op.valid = 1'b1;
                mac_op.shift = 1'b1;
                mac_a        = cur_y_reg;
                mac_b        = {1'b0, vol_reg[15:0]};
            end
            default: ;
        endcase
    end

    // clamp of the volume product, truncation toward zero, mix, volume step
    always_comb begin
        fl     = mac_acc[cbrm_pkg::ACC_W-1:cbrm_pkg::PROD_FRAC];
        fl_top = fl[cbrm_pkg::FL_W-1:cbrm_pkg::SAMPLE_W-1];
        if ((&fl_top) || !(|fl_top)) begin
            pcf_next     = fl[cbrm_pkg::SAMPLE_W-1:0];
            // just above the top limit the clamp leaves no fraction
            frac_nz_next = (|mac_acc[cbrm_pkg::PROD_FRAC-1:0]) &&
                           (fl[cbrm_pkg::SAMPLE_W-1:0] != 32'h7fff_ffff);
        end else begin
            pcf_next     = fl[cbrm_pkg::FL_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            frac_nz_next = 1'b0;
        end
        contrib_next = pcf_next + 32'(pcf_next[31] && frac_nz_next);

        msum = {m_reg[31], m_reg} + {pcf_reg[31], pcf_reg};
        if (msum[32] != msum[31])
            mix_val = msum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            mix_val = msum[31:0] + 32'(msum[31] && frac_nz_reg);

        vsum = {vol_reg[31], vol_reg} + {cfg.vol_step[31], cfg.vol_step};
        if (vsum[32] != vsum[31])
            vol_next = vsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            vol_next = vsum[31:0];
    end

    assign out_load    = (state_reg == ST_MIX) && !out_hold;
    assign out_mix     = mix_val;
    assign out_contrib = contrib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tap_reg   <= '0;
            x1_reg    <= '0;
            x2_reg    <= '0;
            y1a_reg   <= '0;
            y2a_reg   <= '0;
            x1b_reg   <= '0;
            x2b_reg   <= '0;
            y1b_reg   <= '0;
            y2b_reg   <= '0;
            vol_reg   <= '0;
            for (int i = 0; i < 4; i++) begin
                saved1_reg[i] <= '0;
                saved2_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        x_reg     <= in_pcm;
                        m_reg     <= in_mix;
                        tap_reg   <= '0;
                        state_reg <= in_frame ? ST_SYNC : ST_S1_MAC;
                    end
                end
                ST_SYNC: begin
                    if (cfg.mode[cbrm_pkg::MODE_CLR1]) begin
                        x1_reg  <= '0;
                        x2_reg  <= '0;
                        y1a_reg <= '0;
                        y2a_reg <= '0;
                    end else if (cfg.mode[cbrm_pkg::MODE_SAVE]) begin
                        saved1_reg[0] <= cbrm_pkg::STATE_WIDTH'(x1_reg);
                        saved1_reg[1] <= cbrm_pkg::STATE_WIDTH'(x2_reg);
                        saved1_reg[2] <= y1a_reg;
                        saved1_reg[3] <= y2a_reg;
                    end else begin
                        x1_reg  <= saved1_reg[0][cbrm_pkg::SAMPLE_W-1:0];
                        x2_reg  <= saved1_reg[1][cbrm_pkg::SAMPLE_W-1:0];
                        y1a_reg <= saved1_reg[2];
                        y2a_reg <= saved1_reg[3];
                    end
                    if (cfg.mode[cbrm_pkg::MODE_CLR2]) begin
                        x1b_reg <= '0;
                        x2b_reg <= '0;
                        y1b_reg <= '0;
                        y2b_reg <= '0;
                    end else if (cfg.mode[cbrm_pkg::MODE_SAVE]) begin
                        saved2_reg[0] <= x1b_reg;
                        saved2_reg[1] <= x2b_reg;
                        saved2_reg[2] <= y1b_reg;
                        saved2_reg[3] <= y2b_reg;
                    end else begin
                        x1b_reg <= saved2_reg[0];
                        x2b_reg <= saved2_reg[1];
                        y1b_reg <= saved2_reg[2];
                        y2b_reg <= saved2_reg[3];
                    end
                    vol_reg   <= cfg.start_vol;
                    state_reg <= ST_S1_MAC;
                end
                ST_S1_MAC: begin
                    if (tap_reg == cbrm_pkg::TAP_W'(cbrm_pkg::TAPS - 1)) begin
                        tap_reg   <= '0;
                        state_reg <= ST_S1_DRAIN;
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_S1_DRAIN: state_reg <= ST_S1_DONE;
                ST_S1_DONE: begin
                    x2_reg    <= x1_reg;
                    x1_reg    <= x_reg;
                    y2a_reg   <= y1a_reg;
                    y1a_reg   <= y_sat;
                    cur_y_reg <= y_sat;
                    state_reg <= ST_S2_MAC;
                end
                ST_S2_MAC: begin
                    if (tap_reg == cbrm_pkg::TAP_W'(cbrm_pkg::TAPS - 1)) begin
                        tap_reg   <= '0;
                        state_reg <= ST_S2_DRAIN;
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_S2_DRAIN: state_reg <= ST_S2_DONE;
                ST_S2_DONE: begin
                    x2b_reg   <= x1b_reg;
                    x1b_reg   <= cur_y_reg;
                    y2b_reg   <= y1b_reg;
                    y1b_reg   <= y_sat;
                    cur_y_reg <= y_sat;
                    state_reg <= ST_VOL_HI;
                end
                ST_VOL_HI:    state_reg <= ST_VOL_LO;
                ST_VOL_LO:    state_reg <= ST_VOL_DRAIN;
                ST_VOL_DRAIN: state_reg <= ST_CLAMP;
                ST_CLAMP: begin
                    pcf_reg     <= pcf_next;
                    frac_nz_reg <= frac_nz_next;
                    contrib_reg <= contrib_next;
                    vol_reg     <= vol_next;
                    state_reg   <= ST_MIX;
                end
                ST_MIX: begin
                    if (!out_hold)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/cascaded_biquad_ramped_mix_core.sv
// Two cascaded direct-form-I biquads (Q2.14 coefficients, Q32.16 state in 48 bits,
// feedback terms added), then a per-sample ramped Q8.24 volume with saturation to
// 32 bits (contribution) and a saturating add onto the mix-buffer word (mix_out).
// One multiply-accumulate unit is shared by all twelve products (five taps per
// biquad plus two volume partial products). Each biquad pass has five MAC steps,
// a drain step for the multiplier register and a step to saturate and shift the
// history; the volume pass has two MAC steps, a drain, a clamp and the mix step.
// m_tvalid rises after the mix step; when tuser marks a frame start, an extra step
// first clears, saves or restores the stage states and reloads the volume.
// s_tready comes back in the same cycle that m_tvalid rises, so input words keep
// being taken as long as m_tready keeps up.
// s_tready is high only while the sequencer is idle; a finished word waits in
// the output register, so a new word is accepted while the last is not yet taken.
// If the last word is still held when the next one is done, the sequencer waits.
// Config writes go through cfg_* and are always taken; write only while idle.
module cascaded_biquad_ramped_mix_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [63:0]                       s_tdata,   // pcm_sample [31:0], mix_in [63:32]
    input  logic                              s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata,   // mix_out [31:0], contribution [63:32]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cbrm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbrm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cbrm_pkg::cfg_t     cfg_reg;
    cbrm_pkg::mac_op_t  mac_op;
    cbrm_pkg::state_t   mac_a;
    cbrm_pkg::mul_b_t   mac_b;
    cbrm_pkg::acc_t     mac_acc;
    cbrm_pkg::sample_t  out_mix, out_contrib;
    logic               out_load, out_hold;
    logic               m_tvalid_reg;
    logic [63:0]        m_tdata_reg;

    assign cfg_ready = 1'b1;

    // Register file; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ff1       <= 48'd16384;
            cfg_reg.fb1       <= '0;
            cfg_reg.ff2       <= 48'd16384;
            cfg_reg.fb2       <= '0;
            cfg_reg.start_vol <= 32'sd16777216;
            cfg_reg.vol_step  <= '0;
            cfg_reg.mode      <= 3'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                cbrm_pkg::CFG_S1_FF: cfg_reg.ff1       <= cfg_data;
                cbrm_pkg::CFG_S1_FB: cfg_reg.fb1       <= cfg_data[31:0];
                cbrm_pkg::CFG_S2_FF: cfg_reg.ff2       <= cfg_data;
                cbrm_pkg::CFG_S2_FB: cfg_reg.fb2       <= cfg_data[31:0];
                cbrm_pkg::CFG_VOL:   cfg_reg.start_vol <= cfg_data[31:0];
                cbrm_pkg::CFG_STEP:  cfg_reg.vol_step  <= cfg_data[31:0];
                cbrm_pkg::CFG_MODE:  cfg_reg.mode      <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    cbrm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_pcm      (s_tdata[31:0]),
        .in_mix      (s_tdata[63:32]),
        .in_frame    (s_tuser),
        .cfg         (cfg_reg),
        .out_hold    (out_hold),
        .out_load    (out_load),
        .out_mix     (out_mix),
        .out_contrib (out_contrib),
        .mac_op      (mac_op),
        .mac_a       (mac_a),
        .mac_b       (mac_b),
        .mac_acc     (mac_acc)
    );

    cbrm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .a       (mac_a),
        .b       (mac_b),
        .acc     (mac_acc)
    );

    // Output register: the sequencer only loads it when it is empty or being drained
    assign out_hold = m_tvalid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load)
            m_tdata_reg <= {out_contrib, out_mix};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hw/rtl/cbrm_checker.sv
module cbrm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [63:0]                       m_tdata,
    input logic                              cfg_ready
);

    // busy for a while after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again too early");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port stalled");

endmodule

bind cascaded_biquad_ramped_mix_core cbrm_checker u_cbrm_checker (.*);
